/* hdl/tks_pkg.sv */
// Shared types and constants of the table key search block.
// Used by the interfaces, tks_alu and table_key_search; depends on nothing.
package tks_pkg;

    // Table geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = 4;
    localparam int COUNT_W = 5;
    localparam int WORD_W  = 32;

    // Width of the shared subtractor: holds the interpolation numerator with a sign
    localparam int REM_W = 36;
    localparam int ALU_W = 37;

    // Item modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_BINARY = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;
    localparam logic [1:0] MODE_INTERP = 2'd3;

    // Result of the shared subtractor
    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             neg;
        logic             zero;
    } alu_res_t;

endpackage

/* hdl/tks_intf.sv */
// Channel interfaces of the table key search block: request, result and configuration.
// Depends on tks_pkg for field widths.
interface tks_req_if
    import tks_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [ADDR_W-1:0] entry_index;
    logic signed [WORD_W-1:0] item_value;

    modport source (output valid, output mode, output entry_index, output item_value,
                    input ready);
    modport sink   (input valid, input mode, input entry_index, input item_value,
                    output ready);
endinterface

interface tks_rsp_if
    import tks_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

interface tks_cfg_if
    import tks_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, output entry_count, input ready);
    modport sink   (input valid, input entry_count, output ready);
endinterface

/* hdl/tks_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

/* hdl/tks_alu.sv */
// Shared subtractor used for every key compare and every division step of a search.
// Depends on tks_pkg for its width and result type.
module tks_alu
    import tks_pkg::*;
(
    input  logic [ALU_W-1:0] op_a,
    input  logic [ALU_W-1:0] op_b,
    output alu_res_t         res
);
    logic [ALU_W-1:0] diff;

    // One wide subtraction; the sign and zero flags drive all decisions
    always_comb
    begin
        diff     = op_a - op_b;
        res.diff = diff;
        res.neg  = diff[ALU_W-1];
        res.zero = (diff == '0);
    end
endmodule

/* hdl/table_key_search.sv */
// Table key search: a load writes one table entry; a search runs a check state and a
// compare state per probe, then a done state, as a linear scan or a binary search.
// An interpolation probe makes three table reads and a 4-step division through the
// shared subtractor. One item is in work at a time; the result waits in an output
// register. Reset clears the sequencer, the output valid and entry_count; the table
// holds no defined data until written.
module table_key_search
    import tks_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tks_req_if.sink       req,
    tks_rsp_if.source     rsp,
    tks_cfg_if.sink       cfg
);
    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_AL    = 3'd3;
    localparam logic [2:0] S_AR    = 3'd4;
    localparam logic [2:0] S_DEN   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    // Control registers
    logic [2:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers
    logic [1:0]              mode_reg, mode_next;
    logic [WORD_W-1:0]       key_reg, key_next;
    logic [COUNT_W-1:0]      lo_reg, lo_next;
    logic [COUNT_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [WORD_W-1:0]       al_reg, al_next;
    logic [WORD_W-1:0]       ar_reg, ar_next;
    logic [WORD_W-1:0]       kd_reg, kd_next;
    logic [WORD_W-1:0]       den_reg, den_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ADDR_W-1:0]       quo_reg, quo_next;
    logic [1:0]              step_reg, step_next;
    logic                    hit_reg, hit_next;
    logic [ADDR_W-1:0]       pos_reg, pos_next;
    logic                    found_out_reg, found_out_next;
    logic [ADDR_W-1:0]       pos_out_reg, pos_out_next;

    // Datapath signals
    logic                    accept;
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [WORD_W-1:0]       rd_data;
    logic [ALU_W-1:0]        op_a, op_b;
    alu_res_t                alu_res;
    logic [COUNT_W:0]        mid_sum;
    logic [ADDR_W-1:0]       mid_bin;
    logic [COUNT_W-1:0]      span;
    logic [REM_W-1:0]        product;
    logic [ADDR_W-1:0]       quo_final;
    logic [ADDR_W-1:0]       mid_interp;
    logic [COUNT_W-1:0]      used_count;

    // Handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = found_out_reg;
    assign rsp.position = pos_out_reg;

    // Table store
    assign ram_wr_en = accept && (req.mode == MODE_LOAD)
                       && ({1'b0, req.entry_index} < DEPTH_C);

    tks_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req.entry_index),
        .wr_data (req.item_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Probe arithmetic
    assign used_count = (count_reg > DEPTH_C) ? DEPTH_C : count_reg;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (COUNT_W+1)'(1);
    assign mid_bin    = mid_sum[ADDR_W:1];
    assign span       = hi_reg - COUNT_W'(1) - lo_reg;
    assign product    = {32'd0, span[ADDR_W-1:0]} * {4'd0, kd_reg};
    assign quo_final  = alu_res.neg ? quo_reg : (quo_reg | (ADDR_W'(1) << step_reg));
    assign mid_interp = lo_reg[ADDR_W-1:0] + quo_final;

    // Read address for the next cycle
    always_comb
    begin
        case (state_reg)
            S_CHECK:
            begin
                rd_addr = (mode_reg == MODE_BINARY) ? mid_bin : lo_reg[ADDR_W-1:0];
            end
            S_AL:
            begin
                rd_addr = span[ADDR_W-1:0] + lo_reg[ADDR_W-1:0];
            end
            S_DIV:
            begin
                rd_addr = mid_interp;
            end
            default:
            begin
                rd_addr = mid_reg;
            end
        endcase
    end

    // Operand selection for the shared subtractor
    always_comb
    begin
        case (state_reg)
            S_AR:
            begin
                op_a = ALU_W'($signed(rd_data));
                op_b = ALU_W'($signed(key_reg));
            end
            S_DEN:
            begin
                op_a = ALU_W'($signed(ar_reg));
                op_b = ALU_W'($signed(al_reg));
            end
            S_DIV:
            begin
                op_a = {1'b0, rem_reg};
                op_b = ALU_W'(den_reg) << step_reg;
            end
            default:
            begin
                op_a = ALU_W'($signed(key_reg));
                op_b = ALU_W'($signed(rd_data));
            end
        endcase
    end

    tks_alu u_alu (
        .op_a (op_a),
        .op_b (op_b),
        .res  (alu_res)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        al_next        = al_reg;
        ar_next        = ar_reg;
        kd_next        = kd_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        found_out_next = found_out_reg;
        pos_out_next   = pos_out_reg;

        if (cfg.valid && cfg.ready)
        begin
            count_next = cfg.entry_count;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.mode != MODE_LOAD))
                begin
                    mode_next  = req.mode;
                    key_next   = req.item_value;
                    lo_next    = '0;
                    hi_next    = used_count;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (lo_reg >= hi_reg)
                begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else if (mode_reg == MODE_INTERP)
                begin
                    state_next = S_AL;
                end
                else
                begin
                    mid_next   = rd_addr;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (alu_res.zero)
                begin
                    hit_next   = 1'b1;
                    pos_next   = mid_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    if (mode_reg == MODE_LINEAR)
                    begin
                        lo_next = lo_reg + COUNT_W'(1);
                    end
                    else if (!alu_res.neg)
                    begin
                        // Probe below the key: continue in the upper part
                        lo_next = {1'b0, mid_reg} + COUNT_W'(1);
                    end
                    else
                    begin
                        hi_next = {1'b0, mid_reg};
                    end
                    state_next = S_CHECK;
                end
            end
            S_AL:
            begin
                // Key below the low end value: not in range
                al_next = rd_data;
                kd_next = alu_res.diff[WORD_W-1:0];
                if (alu_res.neg)
                begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_AR;
                end
            end
            S_AR:
            begin
                // Key above the high end value: not in range
                ar_next = rd_data;
                if (alu_res.neg)
                begin
                    hit_next   = 1'b0;
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                if (alu_res.zero)
                begin
                    // Both ends hold the same value: decide directly
                    hit_next   = (kd_reg == '0);
                    pos_next   = (kd_reg == '0) ? lo_reg[ADDR_W-1:0] : '0;
                    state_next = S_DONE;
                end
                else
                begin
                    den_next   = alu_res.diff[WORD_W-1:0];
                    rem_next   = product;
                    quo_next   = '0;
                    step_next  = 2'd3;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                if (!alu_res.neg)
                begin
                    rem_next = alu_res.diff[REM_W-1:0];
                end
                quo_next = quo_final;
                if (step_reg == 2'd0)
                begin
                    mid_next   = mid_interp;
                    state_next = S_CMP;
                end
                else
                begin
                    step_next = step_reg - 2'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    found_out_next = hit_reg;
                    pos_out_next   = pos_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result data
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        al_reg        <= al_next;
        ar_reg        <= ar_next;
        kd_reg        <= kd_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        found_out_reg <= found_out_next;
        pos_out_reg   <= pos_out_next;
    end
endmodule

/* verif/tb_table_key_search.sv */
// Self-checking testbench for table_key_search: loads, binary, linear and interpolation searches.
// Depends on tks_pkg and the channel interfaces in tks_intf.sv; results are predicted in place.
module tb_table_key_search
    import tks_pkg::*;
;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int PHASE_SEARCHES = 30;
    localparam int IDLE_PERCENT  = 14;
    localparam int STEADY_FROM   = 2500;
    localparam int STEADY_TO     = 5500;
    localparam int NUM_ROWS      = 29;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } search_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [1:0]               mode;
        logic [ADDR_W-1:0]        index;
        logic signed [WORD_W-1:0] value;
        logic                     typed;
        search_result_t           result;
    } plan_row_t;

    // Directed plan: searches on an empty table, a sorted fill with both extremes, then
    // counts above the depth, a single entry (equal ends) and the full depth.
    plan_row_t plan_rows [NUM_ROWS] = '{
        '{ROW_ITEM, MODE_BINARY, 4'd0,  32'sd0,          1'b1, '{1'b0, 4'd0}},
        '{ROW_ITEM, MODE_LINEAR, 4'd0,  32'h8000_0000,   1'b1, '{1'b0, 4'd0}},
        '{ROW_ITEM, MODE_INTERP, 4'd0,  32'h7FFF_FFFF,   1'b1, '{1'b0, 4'd0}},
        '{ROW_ITEM, MODE_LOAD,   4'd0,  32'h8000_0000,   1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd1,  -32'sd1000000,   1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd2,  -32'sd65536,     1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd3,  -32'sd300,       1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd4,  -32'sd7,         1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd5,  -32'sd1,         1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd6,  32'sd0,          1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd7,  32'sd1,          1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd8,  32'sd5,          1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd9,  32'sd42,         1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd10, 32'sd1000,       1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd11, 32'sd65535,      1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd12, 32'sd123456789,  1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd13, 32'sd1000000000, 1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd14, 32'sd2000000000, 1'b0, '0},
        '{ROW_ITEM, MODE_LOAD,   4'd15, 32'h7FFF_FFFF,   1'b0, '0},
        '{ROW_CFG,  MODE_LOAD,   4'd0,  32'sd31,         1'b0, '0},
        '{ROW_ITEM, MODE_LINEAR, 4'd0,  32'h8000_0000,   1'b1, '{1'b1, 4'd0}},
        '{ROW_ITEM, MODE_INTERP, 4'd0,  32'h7FFF_FFFF,   1'b1, '{1'b1, 4'd15}},
        '{ROW_ITEM, MODE_BINARY, 4'd0,  -32'sd7,         1'b0, '0},
        '{ROW_CFG,  MODE_LOAD,   4'd0,  32'sd1,          1'b0, '0},
        '{ROW_ITEM, MODE_INTERP, 4'd0,  32'h8000_0000,   1'b1, '{1'b1, 4'd0}},
        '{ROW_ITEM, MODE_LINEAR, 4'd0,  32'sd42,         1'b0, '0},
        '{ROW_CFG,  MODE_LOAD,   4'd0,  32'sd16,         1'b0, '0},
        '{ROW_ITEM, MODE_BINARY, 4'd0,  32'sd43,         1'b0, '0},
        '{ROW_ITEM, MODE_INTERP, 4'd0,  32'sd1000,       1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    tks_req_if req_bus();
    tks_rsp_if rsp_bus();
    tks_cfg_if cfg_bus();

    table_key_search u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Shadow copy of the block's table and entry count.
    int             shadow_table [DEPTH];
    int unsigned    shadow_count;
    search_result_t pending_results [$];
    search_result_t oldest_result;

    int          error_count = 0;
    int          found_hits = 0;
    int          stim_items = 0;
    int          mode_tally [4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;
    logic        steady;

    // Clock generation.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A window in which neither side holds back at all.
    assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

    // Search over the shadow table; returns the matching index or -1.
    function automatic int lookup_key(input logic [1:0] mode, input int key);
        int     lo;
        int     hi;
        int     mid;
        int     used;
        longint al;
        longint ar;
        longint num;
        longint den;
        used = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
        lo = 0;
        hi = used - 1;
        case (mode)
            MODE_BINARY:
            begin
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_table[mid] == key)
                        return mid;
                    if (shadow_table[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            MODE_LINEAR:
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (shadow_table[i] == key)
                        return i;
                end
            end
            default:
            begin
                // Interpolation: the probe is exact integer arithmetic, truncated.
                while (lo <= hi && key >= shadow_table[lo] && key <= shadow_table[hi])
                begin
                    al = shadow_table[lo];
                    ar = shadow_table[hi];
                    if (al == ar)
                        return (al == key) ? lo : -1;
                    num = longint'(hi - lo) * (longint'(key) - al);
                    den = ar - al;
                    mid = lo + int'(num / den);
                    if (shadow_table[mid] == key)
                        return mid;
                    if (shadow_table[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
        endcase
        return -1;
    endfunction

    // Presents one request and waits for its transfer. Called and left at a falling edge;
    // valid stays high so that a following request can go out without a gap.
    task automatic send_item(input logic [1:0] mode, input logic [ADDR_W-1:0] index,
                             input int value, input logic typed,
                             input search_result_t typed_result);
        search_result_t want;
        int             hit;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.valid       = 1'b1;
        req_bus.mode        = mode;
        req_bus.entry_index = index;
        req_bus.item_value  = value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        // The transfer has happened at this edge.
        if (mode == MODE_LOAD)
        begin
            shadow_table[index] = value;
        end
        else
        begin
            if (typed)
            begin
                want = typed_result;
            end
            else
            begin
                hit = lookup_key(mode, value);
                want.found    = (hit >= 0);
                want.position = (hit >= 0) ? hit[ADDR_W-1:0] : '0;
            end
            pending_results.push_back(want);
        end
        mode_tally[mode]++;
        stim_items++;
        @(negedge clk);
    endtask

    // Writes entry_count once the block has drained and settled.
    task automatic write_entry_count(input logic [COUNT_W-1:0] count);
        req_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_bus.entry_count = count;
        cfg_bus.valid       = 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        shadow_count = 32'(count);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Result side: random back-pressure, changed at the falling edge.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_bus.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare each result transfer with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: found %0d, position %0d",
                       rsp_bus.found, rsp_bus.position);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp_bus.found !== oldest_result.found)
                begin
                    $error("found: expected %0d, actual %0d",
                           oldest_result.found, rsp_bus.found);
                    error_count++;
                end
                if (rsp_bus.position !== oldest_result.position)
                begin
                    $error("position: expected %0d, actual %0d",
                           oldest_result.position, rsp_bus.position);
                    error_count++;
                end
                if (oldest_result.found)
                    found_hits++;
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Main stimulus sequence.
    initial
    begin
        int                 fill [DEPTH];
        int                 tmp;
        int                 j;
        int                 style;
        int                 base;
        int                 step;
        int                 used;
        int                 key;
        int                 pick;
        int                 offset;
        int                 phase;
        int                 random_goal;
        logic [COUNT_W-1:0] count;
        logic [1:0]         mode;

        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.mode        = MODE_LOAD;
        req_bus.entry_index = '0;
        req_bus.item_value  = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.entry_count = '0;
        shadow_count        = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_table[i] = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (plan_rows[r].kind == ROW_CFG)
                write_entry_count(plan_rows[r].value[COUNT_W-1:0]);
            else
                send_item(plan_rows[r].mode, plan_rows[r].index, plan_rows[r].value,
                          plan_rows[r].typed, plan_rows[r].result);
        end

        // Random part: per phase a new count, a fresh fill of the whole table, then
        // mostly searches with an occasional stray load that may break the ordering.
        random_goal = stim_items + RANDOM_ITEMS;
        phase = 0;
        while (stim_items < random_goal)
        begin
            if (phase == 0)
                count = '0;
            else
            begin
                case ($urandom_range(5))
                    0:       count = '0;
                    1:       count = COUNT_W'(DEPTH);
                    2:       count = '1;
                    3:       count = COUNT_W'(1);
                    default: count = COUNT_W'($urandom_range(30, 2));
                endcase
            end
            write_entry_count(count);

            style = $urandom_range(5);
            base  = $urandom;
            step  = $urandom_range(1000, 1);
            for (int i = 0; i < DEPTH; i++)
            begin
                case (style)
                    1:       fill[i] = int'($urandom_range(20)) - 10;
                    2:       fill[i] = base;
                    3:       fill[i] = (base >>> 12) + i * step;
                    default: fill[i] = $urandom;
                endcase
            end
            // Every style but the scrambled one is kept in ascending order.
            if (style != 4)
            begin
                for (int a = 1; a < DEPTH; a++)
                begin
                    tmp = fill[a];
                    j = a - 1;
                    while (j >= 0 && fill[j] > tmp)
                    begin
                        fill[j + 1] = fill[j];
                        j--;
                    end
                    fill[j + 1] = tmp;
                end
            end
            if (style == 5)
            begin
                fill[0]         = 32'h8000_0000;
                fill[DEPTH - 1] = 32'h7FFF_FFFF;
            end
            offset = $urandom_range(DEPTH - 1);
            for (int i = 0; i < DEPTH; i++)
            begin
                j = (i + offset) % DEPTH;
                send_item(MODE_LOAD, j[ADDR_W-1:0], fill[j], 1'b0, '0);
            end

            used = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
            for (int s = 0; s < PHASE_SEARCHES; s++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    j = $urandom_range(DEPTH - 1);
                    send_item(MODE_LOAD, j[ADDR_W-1:0], $urandom, 1'b0, '0);
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (used > 0 && pick < 60)
                        key = shadow_table[$urandom_range(used - 1)];
                    else if (used > 0 && pick < 80)
                        key = shadow_table[$urandom_range(used - 1)]
                              + (($urandom_range(1) == 1) ? 1 : -1);
                    else
                        key = $urandom;
                    mode = 2'($urandom_range(3, 1));
                    j = $urandom_range(DEPTH - 1);
                    send_item(mode, j[ADDR_W-1:0], key, 1'b0, '0);
                end
            end
            phase++;
        end

        // Drain and report.
        req_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d loads and %0d binary, %0d linear, %0d interpolation searches",
                 mode_tally[MODE_LOAD], mode_tally[MODE_BINARY], mode_tally[MODE_LINEAR],
                 mode_tally[MODE_INTERP]);
        $display("over %0d random table settings; %0d searches found their key, %0d errors",
                 phase, found_hits, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hdl/tks_pkg.sv
hdl/tks_intf.sv
hdl/tks_ram.sv
hdl/tks_alu.sv
hdl/table_key_search.sv
verif/tb_table_key_search.sv
